// File: hdl/qwspwm_pkg.sv
package qwspwm_pkg;

	localparam int NUM_REGS = 4;
	localparam int NUM_QP_REGS = 3;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;
	localparam logic [7:0] QP_RESET = 8'd100;

	localparam logic [1:0] REG_ENABLE_MASK = 2'd0;
	localparam logic [1:0] REG_QP_CH0 = 2'd1;
	localparam logic [1:0] REG_QP_CH1 = 2'd2;
	localparam logic [1:0] REG_QP_CH2 = 2'd3;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic [1:0] QUARTER_RISE_POS = 2'd0;
	localparam logic [1:0] QUARTER_RISE_NEG = 2'd2;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_WRITE = 1'b1
	} op_kind_t;

	typedef struct packed {
		logic action;
		logic [1:0] channel;
		logic [7:0] entry_index;
		logic [9:0] entry_value;
	} item_t;

	typedef struct packed {
		logic [1:0] out_channel;
		logic [9:0] compare_value;
		logic compare_written;
		logic main_on;
		logic comp_on;
		logic [1:0] quarter;
	} result_t;

	typedef struct packed {
		op_kind_t kind;
		logic [1:0] channel;
		logic [7:0] entry_index;
		logic [9:0] entry_value;
	} op_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] tick_count;
		logic high_pending;
		logic low_pending;
		logic main_drive;
		logic comp_drive;
	} chan_state_t;

endpackage

// File: hdl/qwspwm_front.sv
module qwspwm_front #(
	parameter int TABLE_DEPTH = 256,
	parameter int CHANNELS = 3
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input qwspwm_pkg::item_t item,
	output logic op_valid,
	output qwspwm_pkg::op_t op,
	input logic op_pop
);

	localparam int NCH = (CHANNELS < 3) ? CHANNELS : 3;

	qwspwm_pkg::op_t queue_q [qwspwm_pkg::QUEUE_DEPTH];
	logic [qwspwm_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [qwspwm_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [qwspwm_pkg::QUEUE_CNT_W-1:0] count_q;
	logic chan_ok;
	logic keep;
	logic push;
	logic pop;
	qwspwm_pkg::op_t new_op;

	// Items for absent channels and writes past the table end cause nothing and are dropped here.
	always_comb begin
		chan_ok = (32'(item.channel) < NCH);
		keep = chan_ok;
		if (item.action == qwspwm_pkg::ACT_WRITE) begin
			keep = chan_ok && (32'(item.entry_index) < TABLE_DEPTH);
		end
		new_op.kind = (item.action == qwspwm_pkg::ACT_WRITE) ? qwspwm_pkg::OP_WRITE
			: qwspwm_pkg::OP_TICK;
		new_op.channel = item.channel;
		new_op.entry_index = item.entry_index;
		new_op.entry_value = item.entry_value;
	end

	assign item_ready = (count_q != qwspwm_pkg::QUEUE_CNT_W'(qwspwm_pkg::QUEUE_DEPTH));
	assign push = item_valid && item_ready && keep;
	assign op_valid = (count_q != '0);
	assign pop = op_pop && op_valid;
	assign op = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/qwspwm_back.sv
module qwspwm_back #(
	parameter int TABLE_DEPTH = 256,
	parameter int CHANNELS = 3,
	parameter int DUTY_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	input qwspwm_pkg::op_t op,
	output logic op_pop,
	input logic [2:0] enable_mask,
	input logic [qwspwm_pkg::NUM_QP_REGS-1:0][7:0] quarter_points,
	output logic result_valid,
	input logic result_ready,
	output qwspwm_pkg::result_t result
);

	localparam int NCH = (CHANNELS < 3) ? CHANNELS : 3;
	localparam int MEM_DEPTH = NCH * TABLE_DEPTH;
	localparam int AW = $clog2(MEM_DEPTH);

	logic [DUTY_BITS-1:0] mem [MEM_DEPTH];
	logic [DUTY_BITS-1:0] rd_data_s1;

	qwspwm_pkg::chan_state_t st_q [NCH];
	qwspwm_pkg::chan_state_t sel;
	qwspwm_pkg::chan_state_t nxt;
	logic sel_en;
	logic [7:0] sel_qp;
	logic [7:0] n;
	logic [7:0] idx;
	logic idx_ok;
	logic [AW-1:0] base;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	logic s1_free;
	logic tick_go;
	logic write_go;

	logic valid_s1;
	logic [1:0] channel_s1;
	logic written_s1;
	logic idx_ok_s1;
	logic main_s1;
	logic comp_s1;
	logic [1:0] quarter_s1;

	always_comb begin
		sel = st_q[0];
		sel_en = enable_mask[0];
		sel_qp = quarter_points[0];
		for (int c = 1; c < NCH; c++) begin
			if (op.channel == 2'(c)) begin
				sel = st_q[c];
				sel_en = enable_mask[c];
				sel_qp = quarter_points[c];
			end
		end
	end

	always_comb begin
		n = (sel_qp == 8'd0) ? 8'd1 : sel_qp;
		if (!sel.phase[0]) begin
			idx = sel.tick_count;
		end else if (sel.tick_count < n) begin
			idx = n - 8'd1 - sel.tick_count;
		end else begin
			idx = 8'd0;
		end
		idx_ok = (32'(idx) < TABLE_DEPTH);

		nxt = sel;
		if (!sel_en) begin
			nxt.main_drive = 1'b0;
			nxt.comp_drive = 1'b0;
		end else begin
			if (sel.phase == qwspwm_pkg::QUARTER_RISE_POS && sel.high_pending) begin
				nxt.main_drive = 1'b1;
				nxt.comp_drive = 1'b0;
				nxt.high_pending = 1'b0;
				nxt.low_pending = 1'b1;
			end else if (sel.phase == qwspwm_pkg::QUARTER_RISE_NEG && sel.low_pending) begin
				nxt.main_drive = 1'b0;
				nxt.comp_drive = 1'b1;
				nxt.low_pending = 1'b0;
				nxt.high_pending = 1'b1;
			end
			if (sel.tick_count >= n - 8'd1) begin
				nxt.tick_count = 8'd0;
				nxt.phase = sel.phase + 2'd1;
			end else begin
				nxt.tick_count = sel.tick_count + 8'd1;
			end
		end
	end

	assign base = AW'(op.channel) * AW'(TABLE_DEPTH);
	assign rd_addr = base + AW'(idx);
	assign wr_addr = base + AW'(op.entry_index);

	assign s1_free = !valid_s1 || result_ready;
	assign tick_go = op_valid && (op.kind == qwspwm_pkg::OP_TICK) && s1_free;
	assign write_go = op_valid && (op.kind == qwspwm_pkg::OP_WRITE);
	assign op_pop = tick_go || write_go;

	always_ff @(posedge clk) begin
		if (write_go) begin
			mem[wr_addr] <= DUTY_BITS'(op.entry_value);
		end
		if (tick_go) begin
			rd_data_s1 <= mem[rd_addr];
			channel_s1 <= op.channel;
			written_s1 <= sel_en;
			idx_ok_s1 <= idx_ok;
			main_s1 <= nxt.main_drive;
			comp_s1 <= nxt.comp_drive;
			quarter_s1 <= sel.phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int c = 0; c < NCH; c++) begin
				st_q[c] <= '{phase: 2'd0, tick_count: 8'd0, high_pending: 1'b1,
					low_pending: 1'b1, main_drive: 1'b0, comp_drive: 1'b0};
			end
		end else begin
			if (s1_free) begin
				valid_s1 <= tick_go;
			end
			for (int c = 0; c < NCH; c++) begin
				if (tick_go && op.channel == 2'(c)) begin
					st_q[c] <= nxt;
				end
			end
		end
	end

	assign result_valid = valid_s1;
	assign result.out_channel = channel_s1;
	assign result.compare_value = (written_s1 && idx_ok_s1) ? 10'(rd_data_s1) : 10'd0;
	assign result.compare_written = written_s1;
	assign result.main_on = main_s1;
	assign result.comp_on = comp_s1;
	assign result.quarter = quarter_s1;

endmodule

// File: hdl/quarter_wave_spwm_sequencer_core.sv
// Three-channel quarter-wave sine-PWM sequencer. Table writes and ticks are transfers on the
// item channel; each tick of an existing channel yields one result transfer, and writes and
// items for absent channels yield none. The block takes one item per cycle while results are
// taken as offered, and a tick's result is offered from a result register that holds the
// registered read of the duty table memory, loaded when the tick leaves the head of the
// four-entry queue behind the input while that register is empty or being taken.
// Configuration registers sit on the APB port: enable_mask at 0x0 and the quarter-point
// counts of channels 0 to 2 at 0x4, 0x8 and 0xC; a count of zero acts as one.
module quarter_wave_spwm_sequencer_core #(
	parameter int TABLE_DEPTH = 256,
	parameter int CHANNELS = 3,
	parameter int DUTY_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input qwspwm_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output qwspwm_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [qwspwm_pkg::ADDR_W-1:0] paddr,
	input logic [qwspwm_pkg::DATA_W-1:0] pwdata,
	output logic [qwspwm_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	logic [2:0] enable_mask_q;
	logic [qwspwm_pkg::NUM_QP_REGS-1:0][7:0] quarter_points_q;
	logic [1:0] reg_sel;
	logic reg_wr;
	logic op_valid;
	logic op_pop;
	qwspwm_pkg::op_t op;

	assign pready = 1'b1;
	assign reg_sel = paddr[3:2];
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= 3'd0;
			for (int i = 0; i < qwspwm_pkg::NUM_QP_REGS; i++) begin
				quarter_points_q[i] <= qwspwm_pkg::QP_RESET;
			end
		end else if (reg_wr) begin
			case (reg_sel)
				qwspwm_pkg::REG_ENABLE_MASK: enable_mask_q <= pwdata[2:0];
				qwspwm_pkg::REG_QP_CH0: quarter_points_q[0] <= pwdata[7:0];
				qwspwm_pkg::REG_QP_CH1: quarter_points_q[1] <= pwdata[7:0];
				qwspwm_pkg::REG_QP_CH2: quarter_points_q[2] <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			qwspwm_pkg::REG_ENABLE_MASK: prdata = 32'(enable_mask_q);
			qwspwm_pkg::REG_QP_CH0: prdata = 32'(quarter_points_q[0]);
			qwspwm_pkg::REG_QP_CH1: prdata = 32'(quarter_points_q[1]);
			qwspwm_pkg::REG_QP_CH2: prdata = 32'(quarter_points_q[2]);
			default: prdata = '0;
		endcase
	end

	qwspwm_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.CHANNELS(CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.op_valid(op_valid),
		.op(op),
		.op_pop(op_pop)
	);

	qwspwm_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.CHANNELS(CHANNELS),
		.DUTY_BITS(DUTY_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op(op),
		.op_pop(op_pop),
		.enable_mask(enable_mask_q),
		.quarter_points(quarter_points_q),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule

// File: hdl/qwspwm_checker.sv
module qwspwm_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input qwspwm_pkg::item_t item,
	input logic result_valid,
	input logic result_ready,
	input qwspwm_pkg::result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [qwspwm_pkg::ADDR_W-1:0] paddr,
	input logic [qwspwm_pkg::DATA_W-1:0] pwdata,
	input logic [qwspwm_pkg::DATA_W-1:0] prdata,
	input logic pready
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("Result changed or dropped while stalled.");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.main_on && result.comp_on))
		else $error("Main and complementary drivers are both on.");

	a_disabled_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.compare_written |->
		!result.main_on && !result.comp_on && result.compare_value == 10'd0)
		else $error("Disabled channel reported a drive or a compare value.");

	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.out_channel != 2'd3)
		else $error("Result for a channel that does not exist.");

endmodule

bind quarter_wave_spwm_sequencer_core qwspwm_checker u_qwspwm_checker (.*);
